FILE: src/lfu_kvc_pkg.sv
// shared constants, codes and types for the lfu key/value cache
`default_nettype none

package lfu_kvc_pkg;

    localparam int ENTRIES     = 5;
    localparam int KEY_WIDTH   = 32;
    localparam int DATA_WIDTH  = 32;
    localparam int COUNT_WIDTH = 16;
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int FILL_W      = $clog2(ENTRIES + 1);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [FILL_W-1:0]      FILL_FULL = FILL_W'(ENTRIES);

    // operation codes
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_PROBE  = 2'd2,
        OP_REMOVE = 2'd3
    } func_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_MISS  = 2'd1,
        ST_EVICT = 2'd2
    } status_t;

    typedef logic [ENTRIES-1:0][KEY_WIDTH-1:0]   key_arr_t;
    typedef logic [ENTRIES-1:0][DATA_WIDTH-1:0]  data_arr_t;
    typedef logic [ENTRIES-1:0][COUNT_WIDTH-1:0] count_arr_t;

    // result of the parallel key match and least-count search
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] match_idx;
        logic [IDX_W-1:0] victim_idx;
    } scan_t;

endpackage

`default_nettype wire

FILE: src/lfu_kvc_scan.sv
// parallel key match with first-hit priority and least-count victim search
`default_nettype none

module lfu_kvc_scan
    import lfu_kvc_pkg::*;
(
    input  wire key_arr_t          keys,
    input  wire count_arr_t        counts,
    input  wire [FILL_W-1:0]       occupancy,
    input  wire [KEY_WIDTH-1:0]    key,
    output scan_t                  scan
);

    logic [ENTRIES-1:0] match_vec;

    // compare every occupied slot at once
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_vec[i] = (FILL_W'(i) < occupancy) && (keys[i] == key);
        end
    end

    // earliest matching slot wins
    always_comb
    begin
        scan.hit       = |match_vec;
        scan.match_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                scan.match_idx = IDX_W'(i);
            end
        end
    end

    // smallest count, earliest on ties (only strict less moves the pick)
    always_comb
    begin
        logic [COUNT_WIDTH-1:0] best;
        best            = counts[0];
        scan.victim_idx = '0;
        for (int i = 1; i < ENTRIES; i++)
        begin
            if (counts[i] < best)
            begin
                best            = counts[i];
                scan.victim_idx = IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/lfu_key_value_cache_top.sv
// top level of the lfu key/value cache: input stage, update logic, result stage
`default_nettype none

// A five-entry key/value cache with least-frequently-used replacement. An
// operation is accepted on any clock edge where start is high and busy is
// low; busy stays low, so one operation can be issued every cycle. Each
// operation gives exactly one result beat, marked by done: it is captured
// in the input register, then passes through the match and least-count
// logic into the result register and the entry store.
// The result is shown for a single cycle and cannot be held off, so the
// receiver must take it when done is high. Back-to-back operations see the
// store as left by the one before. fill_count gives the entry count after
// the operation; read_data and evicted_key are zero when they do not apply.

module lfu_key_value_cache_top
    import lfu_kvc_pkg::*;
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   start,
    output logic                  busy,
    input  wire [1:0]             func,
    input  wire [KEY_WIDTH-1:0]   entry_key,
    input  wire [DATA_WIDTH-1:0]  entry_data,
    output logic                  done,
    output logic                  hit,
    output logic [1:0]            status,
    output logic [DATA_WIDTH-1:0] read_data,
    output logic [KEY_WIDTH-1:0]  evicted_key,
    output logic [FILL_W-1:0]     fill_count
);

    // input stage
    logic                  in_valid_reg;
    func_t                 in_func_reg;
    logic [KEY_WIDTH-1:0]  in_key_reg;
    logic [DATA_WIDTH-1:0] in_data_reg;

    // entry store
    key_arr_t          key_reg,   key_next;
    data_arr_t         data_reg,  data_next;
    count_arr_t        count_reg, count_next;
    logic [FILL_W-1:0] occ_reg,   occ_next;

    // result stage
    logic                  done_reg;
    logic                  hit_reg,   hit_next;
    status_t               status_reg, status_next;
    logic [DATA_WIDTH-1:0] rdata_reg, rdata_next;
    logic [KEY_WIDTH-1:0]  ekey_reg,  ekey_next;
    logic [FILL_W-1:0]     fill_reg;

    scan_t scan;
    logic  accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // capture the incoming beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_func_reg <= func_t'(func);
            in_key_reg  <= entry_key;
            in_data_reg <= entry_data;
        end
    end

    lfu_kvc_scan u_scan (
        .keys      (key_reg),
        .counts    (count_reg),
        .occupancy (occ_reg),
        .key       (in_key_reg),
        .scan      (scan)
    );

    // store update and result for the registered beat
    always_comb
    begin
        key_next    = key_reg;
        data_next   = data_reg;
        count_next  = count_reg;
        occ_next    = occ_reg;
        hit_next    = 1'b0;
        status_next = ST_OK;
        rdata_next  = '0;
        ekey_next   = '0;

        case (in_func_reg) inside
            OP_ADD:
            begin
                if (occ_reg == FILL_FULL)
                begin
                    // drop the victim, close the gap, append at the tail
                    status_next = ST_EVICT;
                    ekey_next   = key_reg[scan.victim_idx];
                    for (int i = 0; i < ENTRIES - 1; i++)
                    begin
                        if (IDX_W'(i) >= scan.victim_idx)
                        begin
                            key_next[i]   = key_reg[i + 1];
                            data_next[i]  = data_reg[i + 1];
                            count_next[i] = count_reg[i + 1];
                        end
                    end
                    key_next[ENTRIES - 1]   = in_key_reg;
                    data_next[ENTRIES - 1]  = in_data_reg;
                    count_next[ENTRIES - 1] = '0;
                end
                else
                begin
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (FILL_W'(i) == occ_reg)
                        begin
                            key_next[i]   = in_key_reg;
                            data_next[i]  = in_data_reg;
                            count_next[i] = '0;
                        end
                    end
                    occ_next = occ_reg + 1'b1;
                end
            end
            OP_LOOKUP, OP_PROBE, OP_REMOVE:
            begin
                if (!scan.hit)
                begin
                    status_next = ST_MISS;
                end
                else
                begin
                    hit_next = 1'b1;
                    if (in_func_reg == OP_LOOKUP)
                    begin
                        rdata_next = data_reg[scan.match_idx];
                        if (count_reg[scan.match_idx] != COUNT_MAX)
                        begin
                            count_next[scan.match_idx] =
                                count_reg[scan.match_idx] + 1'b1;
                        end
                    end
                    else if (in_func_reg == OP_REMOVE)
                    begin
                        for (int i = 0; i < ENTRIES - 1; i++)
                        begin
                            if (IDX_W'(i) >= scan.match_idx)
                            begin
                                key_next[i]   = key_reg[i + 1];
                                data_next[i]  = data_reg[i + 1];
                                count_next[i] = count_reg[i + 1];
                            end
                        end
                        occ_next = occ_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // control state and counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                occ_reg   <= occ_next;
                count_reg <= count_next;
            end
        end
    end

    // keys, data and result payload
    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            key_reg    <= key_next;
            data_reg   <= data_next;
            hit_reg    <= hit_next;
            status_reg <= status_next;
            rdata_reg  <= rdata_next;
            ekey_reg   <= ekey_next;
            fill_reg   <= occ_next;
        end
    end

    assign done        = done_reg;
    assign hit         = hit_reg;
    assign status      = status_reg;
    assign read_data   = rdata_reg;
    assign evicted_key = ekey_reg;
    assign fill_count  = fill_reg;

    // checks
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 done)
        else $error("result beat missing after accepted operation");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= FILL_FULL)
        else $error("occupancy above entry count");

    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EVICT) |-> (fill_count == FILL_FULL && !hit))
        else $error("eviction reported without a full store");

    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (status == ST_OK))
        else $error("hit with non-ok status");

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// self-checking testbench for the lfu key/value cache top level
`timescale 1ns / 1ps

module tb_top;
    import lfu_kvc_pkg::*;

    // one operation beat plus the idle cycles that follow it
    typedef struct {
        func_t                 op;
        logic [KEY_WIDTH-1:0]  key;
        logic [DATA_WIDTH-1:0] data;
        int unsigned           gap;
    } cache_op_t;

    // one result beat
    typedef struct packed {
        logic                  hit;
        status_t               status;
        logic [DATA_WIDTH-1:0] read_data;
        logic [KEY_WIDTH-1:0]  evicted_key;
        logic [FILL_W-1:0]     fill_count;
    } cache_result_t;

    // operation mixes for the random phases
    typedef enum int { MIX_FILL, MIX_DRAIN, MIX_EVEN } mix_t;

    localparam int RANDOM_OPS  = 1250;
    localparam int PHASE_OPS   = 125;
    localparam int HOT_LOOKUPS = 16;
    localparam int POOL_SIZE   = 8;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic [1:0]            func = OP_ADD;
    logic [KEY_WIDTH-1:0]  entry_key = '0;
    logic [DATA_WIDTH-1:0] entry_data = '0;
    logic                  busy;
    logic                  done;
    logic                  hit;
    logic [1:0]            status;
    logic [DATA_WIDTH-1:0] read_data;
    logic [KEY_WIDTH-1:0]  evicted_key;
    logic [FILL_W-1:0]     fill_count;

    // predicted copy of the entry store
    logic [KEY_WIDTH-1:0]   kv_key [ENTRIES];
    logic [DATA_WIDTH-1:0]  kv_data [ENTRIES];
    logic [COUNT_WIDTH-1:0] kv_cnt [ENTRIES];
    int                     kv_fill = 0;

    cache_op_t     pending_ops[$];
    cache_result_t results_due[$];
    cache_op_t     cur_op;
    cache_result_t want;
    logic          go = 1'b0;
    int unsigned   idle_left = 0;
    int            errors = 0;
    logic [KEY_WIDTH-1:0] key_pool [POOL_SIZE];

    lfu_key_value_cache_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .entry_key   (entry_key),
        .entry_data  (entry_data),
        .done        (done),
        .hit         (hit),
        .status      (status),
        .read_data   (read_data),
        .evicted_key (evicted_key),
        .fill_count  (fill_count)
    );

    always #5 clk = ~clk;

    // remove one slot and close the gap
    function automatic void drop_slot(input int slot);
        for (int i = slot; i + 1 < kv_fill; i++)
        begin
            kv_key[i]  = kv_key[i + 1];
            kv_data[i] = kv_data[i + 1];
            kv_cnt[i]  = kv_cnt[i + 1];
        end
        kv_fill = kv_fill - 1;
    endfunction

    // apply one operation to the predicted store and return its result
    function automatic cache_result_t apply_op(input cache_op_t o);
        cache_result_t r;
        int            pos;
        int            victim;
        r = '0;
        r.status = ST_OK;
        if (o.op == OP_ADD)
        begin
            // full store: evict the least-used entry, earliest on ties
            if (kv_fill == ENTRIES)
            begin
                victim = 0;
                for (int i = 1; i < ENTRIES; i++)
                    if (kv_cnt[i] < kv_cnt[victim])
                        victim = i;
                r.evicted_key = kv_key[victim];
                r.status = ST_EVICT;
                drop_slot(victim);
            end
            kv_key[kv_fill]  = o.key;
            kv_data[kv_fill] = o.data;
            kv_cnt[kv_fill]  = '0;
            kv_fill = kv_fill + 1;
        end
        else
        begin
            // earliest matching entry
            pos = -1;
            for (int i = 0; i < kv_fill; i++)
                if (pos < 0 && kv_key[i] == o.key)
                    pos = i;
            if (pos < 0)
                r.status = ST_MISS;
            else
            begin
                r.hit = 1'b1;
                if (o.op == OP_LOOKUP)
                begin
                    r.read_data = kv_data[pos];
                    if (kv_cnt[pos] != COUNT_MAX)
                        kv_cnt[pos] = kv_cnt[pos] + 1'b1;
                end
                else if (o.op == OP_REMOVE)
                    drop_slot(pos);
            end
        end
        r.fill_count = FILL_W'(kv_fill);
        return r;
    endfunction

    // idle length after a beat: mostly none or short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // keys mostly from a small pool so that hits and duplicates are common
    function automatic logic [KEY_WIDTH-1:0] pick_key();
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic func_t pick_func(input mix_t m);
        int unsigned r;
        r = $urandom_range(0, 99);
        case (m)
            MIX_FILL:
            begin
                if (r < 50) return OP_ADD;
                if (r < 75) return OP_LOOKUP;
                if (r < 85) return OP_PROBE;
                return OP_REMOVE;
            end
            MIX_DRAIN:
            begin
                if (r < 20) return OP_ADD;
                if (r < 45) return OP_LOOKUP;
                if (r < 60) return OP_PROBE;
                return OP_REMOVE;
            end
            default:
            begin
                if (r < 35) return OP_ADD;
                if (r < 65) return OP_LOOKUP;
                if (r < 80) return OP_PROBE;
                return OP_REMOVE;
            end
        endcase
    endfunction

    task automatic queue_op(input func_t f, input logic [KEY_WIDTH-1:0] k,
                            input logic [DATA_WIDTH-1:0] d, input int unsigned g);
        cache_op_t o;
        o.op   = f;
        o.key  = k;
        o.data = d;
        o.gap  = g;
        pending_ops.push_back(o);
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
        if (got_v !== exp_v)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $realtime, name,
                     exp_v, got_v);
            errors = errors + 1;
        end
    endtask

    // driver: presents queued beats and predicts each accepted one
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            go = start;
            if (start && !busy)
            begin
                results_due.push_back(apply_op(cur_op));
                idle_left = cur_op.gap;
                go = 1'b0;
            end
            else if (!start && idle_left > 0)
                idle_left = idle_left - 1;
            if (!go && idle_left == 0 && pending_ops.size() > 0)
            begin
                cur_op = pending_ops.pop_front();
                func       <= cur_op.op;
                entry_key  <= cur_op.key;
                entry_data <= cur_op.data;
                go = 1'b1;
            end
            start <= go;
        end
    end

    // monitor: compares each result beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (results_due.size() == 0)
            begin
                $display("%0t: result beat with nothing expected: status %0h fill %0h",
                         $realtime, status, fill_count);
                errors = errors + 1;
            end
            else
            begin
                want = results_due.pop_front();
                check_field("hit", 64'(want.hit), 64'(hit));
                check_field("status", 64'(want.status), 64'(status));
                check_field("read_data", 64'(want.read_data), 64'(read_data));
                check_field("evicted_key", 64'(want.evicted_key), 64'(evicted_key));
                check_field("fill_count", 64'(want.fill_count), 64'(fill_count));
            end
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        logic [KEY_WIDTH-1:0] dir_keys [6];
        mix_t                 mix;
        logic                 no_idle;

        dir_keys[0] = 32'h0000_0000;
        dir_keys[1] = 32'hFFFF_FFFF;
        dir_keys[2] = 32'h1234_5678;
        dir_keys[3] = 32'h8000_0001;
        dir_keys[4] = 32'h0F0F_F0F0;
        dir_keys[5] = 32'h7FFF_FFFE;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        // misses on the empty store
        queue_op(OP_LOOKUP, dir_keys[0], 32'hFFFF_FFFF, pick_gap());
        queue_op(OP_PROBE, dir_keys[1], '0, pick_gap());
        queue_op(OP_REMOVE, dir_keys[0], '0, pick_gap());
        // fill with extreme keys, data and a duplicate key
        queue_op(OP_ADD, dir_keys[0], 32'hFFFF_FFFF, pick_gap());
        queue_op(OP_ADD, dir_keys[1], 32'h0000_0000, pick_gap());
        queue_op(OP_ADD, dir_keys[0], 32'hA5A5_A5A5, pick_gap());
        queue_op(OP_ADD, dir_keys[2], 32'h5A5A_5A5A, pick_gap());
        queue_op(OP_ADD, dir_keys[3], 32'h0000_FFFF, pick_gap());
        // hits act on the earliest duplicate and build up counts
        queue_op(OP_LOOKUP, dir_keys[0], '0, pick_gap());
        queue_op(OP_PROBE, dir_keys[1], '0, pick_gap());
        queue_op(OP_LOOKUP, dir_keys[1], 32'hFFFF_FFFF, pick_gap());
        queue_op(OP_LOOKUP, dir_keys[2], '0, pick_gap());
        queue_op(OP_LOOKUP, dir_keys[2], '0, pick_gap());
        queue_op(OP_LOOKUP, dir_keys[3], '0, pick_gap());
        // evictions on a full store
        queue_op(OP_ADD, dir_keys[4], 32'hFFFF_0000, pick_gap());
        queue_op(OP_ADD, dir_keys[5], 32'h0000_0001, pick_gap());
        // removes, with hits and misses
        queue_op(OP_REMOVE, dir_keys[0], '0, pick_gap());
        queue_op(OP_REMOVE, dir_keys[0], '0, pick_gap());
        queue_op(OP_PROBE, dir_keys[4], '0, pick_gap());
        queue_op(OP_LOOKUP, 32'h0000_3039, '0, pick_gap());
        queue_op(OP_REMOVE, dir_keys[3], '0, pick_gap());
        queue_op(OP_ADD, dir_keys[0], 32'h0000_0000, pick_gap());
        // empty the store again
        for (int r = 0; r < 2; r++)
            for (int i = 0; i < 6; i++)
                queue_op(OP_REMOVE, dir_keys[i], '0, 0);

        // the hot entry must outlive lightly used ones on eviction
        queue_op(OP_ADD, 32'h5A5A_0001, 32'hC0DE_0001, 0);
        for (int i = 0; i < 4; i++)
        begin
            queue_op(OP_ADD, 32'h5A5A_0010 + i, $urandom, 0);
            queue_op(OP_LOOKUP, 32'h5A5A_0010 + i, '0, 0);
            queue_op(OP_LOOKUP, 32'h5A5A_0010 + i, '0, 0);
        end
        for (int i = 0; i < HOT_LOOKUPS; i++)
            queue_op(OP_LOOKUP, 32'h5A5A_0001, '0, 0);
        queue_op(OP_ADD, 32'h5A5A_0020, $urandom, pick_gap());
        queue_op(OP_LOOKUP, 32'h5A5A_0001, '0, pick_gap());

        // random phases alternating fill-heavy, drain-heavy and even mixes
        for (int p = 0; p < RANDOM_OPS / PHASE_OPS; p++)
        begin
            mix = mix_t'(p % 3);
            no_idle = (p % 4 == 3);
            for (int i = 0; i < PHASE_OPS; i++)
                queue_op(pick_func(mix), pick_key(), $urandom,
                         no_idle ? 0 : pick_gap());
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // wait for the last beat and its result
        while (pending_ops.size() != 0 || go || results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (errors == 0 && results_due.size() == 0)
            $display("** lfu_key_value_cache_top: PASSED **");
        else
            $display("** lfu_key_value_cache_top: FAILED **");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("** lfu_key_value_cache_top: FAILED **");
        $finish;
    end

endmodule
